/* rtl/core/spead_beam_header_parser_assert.svh */
// Assertion macros for the SPEAD beam header parser.
`ifndef SPEAD_BEAM_HEADER_PARSER_ASSERT_SVH
`define SPEAD_BEAM_HEADER_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SPB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/spb_pkg.sv */
// Shared types and constants of the SPEAD beam header parser.
package spb_pkg;

    localparam int ADDR_BITS = 48;
    localparam int ID_W      = 63 - ADDR_BITS;
    localparam int COUNT_W   = 16;

    localparam logic [7:0] HDR_MAGIC       = 8'h53;
    localparam logic [7:0] HDR_VERSION     = 8'h04;
    localparam logic [7:0] ITEM_PTR_BYTES  = 8'((64 - ADDR_BITS) / 8);
    localparam logic [7:0] HEAP_ADDR_BYTES = 8'(ADDR_BITS / 8);

    localparam logic [ID_W-1:0] ID_HEAP_COUNTER = ID_W'(16'h0001);
    localparam logic [ID_W-1:0] ID_PAYLOAD_LEN  = ID_W'(16'h0004);
    localparam logic [ID_W-1:0] ID_SYNC_EPOCH   = ID_W'(16'h1027);
    localparam logic [ID_W-1:0] ID_TIME_STAMP   = ID_W'(16'h1600);
    localparam logic [ID_W-1:0] ID_CHANNEL_INFO = ID_W'(16'h2005);
    localparam logic [ID_W-1:0] ID_TILE_INFO    = ID_W'(16'h2003);
    localparam logic [ID_W-1:0] ID_SCAN_ID      = ID_W'(16'h2004);
    localparam logic [ID_W-1:0] ID_DATA_OFFSET  = ID_W'(16'h3300);

    localparam logic [ADDR_BITS-1:0] MODE_BURST   = ADDR_BITS'(8'h08);
    localparam logic [ADDR_BITS-1:0] MODE_INTEG_A = ADDR_BITS'(8'h09);
    localparam logic [ADDR_BITS-1:0] MODE_INTEG_B = ADDR_BITS'(8'h11);

    localparam int POS_W = 3;
    localparam logic [POS_W-1:0] MODE_POSITION = 3'd5;
    localparam logic [POS_W-1:0] POS_SATURATE  = 3'd6;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef enum logic [2:0] {
        ITEM_HEAP,
        ITEM_LENGTH,
        ITEM_SYNC,
        ITEM_STAMP,
        ITEM_CHANNEL,
        ITEM_TILE,
        ITEM_OFFSET,
        ITEM_OTHER
    } item_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_MODE   = 2'd2
    } status_t;

    typedef struct packed {
        logic                 is_header;
        logic                 header_good;
        logic [COUNT_W-1:0]   count;
        item_kind_t           kind;
        logic [ADDR_BITS-1:0] addr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [23:0] heap_counter;
        logic [15:0] heap_index;
        logic [47:0] payload_bytes;
        logic [47:0] sync_epoch;
        logic [47:0] time_stamp;
        logic [7:0]  beam_number;
        logic [15:0] start_channel;
        logic [15:0] included_channels;
        logic [7:0]  tile_number;
        logic [15:0] station_number;
        logic [31:0] data_offset;
    } res_t;

    typedef struct packed {
        logic take;
        logic res_push;
        logic res_full;
    } back_stat_t;

endpackage

/* rtl/core/spb_front.sv */
// Front end: classify each incoming word into a header or item request.
module spb_front
(
    input  logic [63:0]   word,
    input  logic          first,
    output spb_pkg::req_t req
);
    import spb_pkg::*;

    logic [ID_W-1:0] id;

    assign id = word[62:ADDR_BITS];

    always_comb
    begin
        req.is_header   = first;
        req.header_good = (word[63:56] == HDR_MAGIC) &&
                          (word[55:48] == HDR_VERSION) &&
                          (word[47:40] == ITEM_PTR_BYTES) &&
                          (word[39:32] == HEAP_ADDR_BYTES);
        req.count       = word[COUNT_W-1:0];
        req.addr        = word[ADDR_BITS-1:0];
        case (id)
            ID_HEAP_COUNTER: req.kind = ITEM_HEAP;
            ID_PAYLOAD_LEN:  req.kind = ITEM_LENGTH;
            ID_SYNC_EPOCH:   req.kind = ITEM_SYNC;
            ID_TIME_STAMP:   req.kind = ITEM_STAMP;
            ID_CHANNEL_INFO: req.kind = ITEM_CHANNEL;
            ID_TILE_INFO:    req.kind = ITEM_TILE;
            ID_DATA_OFFSET:  req.kind = ITEM_OFFSET;
            ID_SCAN_ID:      req.kind = ITEM_OTHER;
            default:         req.kind = ITEM_OTHER;
        endcase
    end

endmodule

/* rtl/core/spb_req_queue.sv */
// Two-entry request queue between the front and back ends.
module spb_req_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spb_pkg::req_t push_req,
    output logic          full,
    input  logic          pop,
    output spb_pkg::req_t head,
    output logic          valid
);
    import spb_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == QUEUE_DEPTH);
    assign valid   = (count_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* rtl/core/spb_back.sv */
// Back end: track the packet, load item registers and queue the results.
module spb_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               stream_kind_we,
    input  logic               stream_kind,
    input  logic               req_valid,
    input  spb_pkg::req_t      req,
    output logic               req_pop,
    output spb_pkg::res_t      res,
    output logic               empty,
    input  logic               pop,
    output spb_pkg::back_stat_t stat
);
    import spb_pkg::*;

    logic               kind_reg;
    logic [COUNT_W-1:0] items_left_reg;
    logic [COUNT_W-1:0] items_left_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               header_good_reg;
    logic               header_good_next;
    logic               mode_good_reg;
    logic               mode_good_next;
    logic [23:0]        heap_reg;
    logic [23:0]        heap_next;
    logic [15:0]        index_reg;
    logic [15:0]        index_next;
    logic [47:0]        length_reg;
    logic [47:0]        length_next;
    logic [47:0]        sync_reg;
    logic [47:0]        sync_next;
    logic [47:0]        stamp_reg;
    logic [47:0]        stamp_next;
    logic [39:0]        chan_reg;
    logic [39:0]        chan_next;
    logic [23:0]        tile_reg;
    logic [23:0]        tile_next;
    logic [31:0]        offset_reg;
    logic [31:0]        offset_next;
    logic [63:0]        addr64;
    logic               take;
    logic               emit;
    res_t               result;

    res_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       res_full;
    logic       do_pop;

    assign res_full = (count_reg == QUEUE_DEPTH);
    assign take     = req_valid && !res_full;
    assign req_pop  = take;
    assign addr64   = 64'(req.addr);
    assign empty    = (count_reg == 2'd0);
    assign res      = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    assign stat.take     = take;
    assign stat.res_push = emit;
    assign stat.res_full = res_full;

    always_comb
    begin
        items_left_next  = items_left_reg;
        pos_next         = pos_reg;
        header_good_next = header_good_reg;
        mode_good_next   = mode_good_reg;
        heap_next        = heap_reg;
        index_next       = index_reg;
        length_next      = length_reg;
        sync_next        = sync_reg;
        stamp_next       = stamp_reg;
        chan_next        = chan_reg;
        tile_next        = tile_reg;
        offset_next      = offset_reg;
        emit             = 1'b0;
        if (take)
        begin
            if (req.is_header)
            begin
                // start a new packet, drop any in progress
                header_good_next = req.header_good;
                mode_good_next   = 1'b0;
                items_left_next  = req.count;
                pos_next         = '0;
                heap_next        = '0;
                index_next       = '0;
                length_next      = '0;
                sync_next        = '0;
                stamp_next       = '0;
                chan_next        = '0;
                tile_next        = '0;
                offset_next      = '0;
                emit             = (req.count == '0);
            end
            else if (items_left_reg != '0)
            begin
                pos_next = (pos_reg == POS_SATURATE) ? POS_SATURATE : pos_reg + 3'd1;
                case (req.kind)
                    ITEM_HEAP:
                    begin
                        heap_next  = addr64[23:0];
                        index_next = addr64[39:24];
                    end
                    ITEM_LENGTH:  length_next = addr64[47:0];
                    ITEM_SYNC:    sync_next   = addr64[47:0];
                    ITEM_STAMP:   stamp_next  = addr64[47:0];
                    ITEM_CHANNEL: chan_next   = addr64[39:0];
                    ITEM_TILE:    tile_next   = addr64[39:16];
                    ITEM_OFFSET:  offset_next = addr64[31:0];
                    default:      ;
                endcase
                if (pos_next == MODE_POSITION)
                begin
                    mode_good_next = kind_reg ?
                        (req.addr inside {MODE_INTEG_A, MODE_INTEG_B}) :
                        (req.addr == MODE_BURST);
                end
                items_left_next = items_left_reg - 16'd1;
                emit            = (items_left_reg == 16'd1);
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (!header_good_next)
        begin
            result.status = STATUS_BAD_HEADER;
        end
        else if (!mode_good_next)
        begin
            result.status = STATUS_BAD_MODE;
        end
        else
        begin
            result.status            = STATUS_OK;
            result.heap_counter      = heap_next;
            result.heap_index        = index_next;
            result.payload_bytes     = length_next;
            result.sync_epoch        = sync_next;
            result.time_stamp        = stamp_next;
            result.beam_number       = chan_next[39:32];
            result.start_channel     = chan_next[31:16];
            result.included_channels = chan_next[15:0];
            result.tile_number       = tile_next[23:16];
            result.station_number    = tile_next[15:0];
            result.data_offset       = offset_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (emit && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !emit)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= 1'b0;
            items_left_reg  <= '0;
            pos_reg         <= '0;
            header_good_reg <= 1'b0;
            mode_good_reg   <= 1'b0;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= 2'd0;
        end
        else
        begin
            if (stream_kind_we)
            begin
                kind_reg <= stream_kind;
            end
            items_left_reg  <= items_left_next;
            pos_reg         <= pos_next;
            header_good_reg <= header_good_next;
            mode_good_reg   <= mode_good_next;
            wr_ptr_reg      <= emit ? !wr_ptr_reg : wr_ptr_reg;
            rd_ptr_reg      <= do_pop ? !rd_ptr_reg : rd_ptr_reg;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        heap_reg   <= heap_next;
        index_reg  <= index_next;
        length_reg <= length_next;
        sync_reg   <= sync_next;
        stamp_reg  <= stamp_next;
        chan_reg   <= chan_next;
        tile_reg   <= tile_next;
        offset_reg <= offset_next;
        if (emit)
        begin
            slot_reg[wr_ptr_reg] <= result;
        end
    end

endmodule

/* rtl/core/spead_beam_header_parser.sv */
// Top level of the SPEAD-64-48 beam packet header parser.
//
// Input: write one 64-bit word per request with push while full is low; raise
// first on the SPEAD header word, then send the item pointer words it counts.
// Output: while empty is low the ports show the oldest packet result; take it
// with pop. One result follows the last item word (or a header with no items).
// Configuration: stream_kind_we writes stream_kind (0 burst, 1 integrated)
// at once; write it only while no packet is in flight.
// Path: an accepted word is registered in the two-entry request queue; the back
// end decodes the queue head and registers each packet result in the two-entry
// result queue, whose oldest entry the ports show and pop takes.
// Throughput: one word per cycle while full is low; the request and result queues
// each take a write and a read in the same cycle unless they are full.
// Stall: when pop stays low the two-entry result queue fills, the back end
// holds, the request queue fills and full rises; nothing is dropped.
// Reset: both queues are empty, no packet is open and stream_kind is 0.
module spead_beam_header_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stream_kind_we,
    input  logic        stream_kind,
    input  logic        push,
    output logic        full,
    input  logic [63:0] word,
    input  logic        first,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [23:0] heap_counter,
    output logic [15:0] heap_index,
    output logic [47:0] payload_bytes,
    output logic [47:0] sync_epoch,
    output logic [47:0] time_stamp,
    output logic [7:0]  beam_number,
    output logic [15:0] start_channel,
    output logic [15:0] included_channels,
    output logic [7:0]  tile_number,
    output logic [15:0] station_number,
    output logic [31:0] data_offset
);
    import spb_pkg::*;

    `include "spead_beam_header_parser_assert.svh"

    req_t       front_req;
    req_t       head_req;
    logic       head_valid;
    logic       head_pop;
    res_t       res;
    back_stat_t stat;

    spb_front u_front
    (
        .word  (word),
        .first (first),
        .req   (front_req)
    );

    spb_req_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (front_req),
        .full     (full),
        .pop      (head_pop),
        .head     (head_req),
        .valid    (head_valid)
    );

    spb_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .stream_kind_we (stream_kind_we),
        .stream_kind    (stream_kind),
        .req_valid      (head_valid),
        .req            (head_req),
        .req_pop        (head_pop),
        .res            (res),
        .empty          (empty),
        .pop            (pop),
        .stat           (stat)
    );

    assign status            = res.status;
    assign heap_counter      = res.heap_counter;
    assign heap_index        = res.heap_index;
    assign payload_bytes     = res.payload_bytes;
    assign sync_epoch        = res.sync_epoch;
    assign time_stamp        = res.time_stamp;
    assign beam_number       = res.beam_number;
    assign start_channel     = res.start_channel;
    assign included_channels = res.included_channels;
    assign tile_number       = res.tile_number;
    assign station_number    = res.station_number;
    assign data_offset       = res.data_offset;

    `SPB_ASSERT_IMPLY(a_take_needs_request, clk, rst_n, stat.take, head_valid)
    `SPB_ASSERT_IMPLY(a_push_needs_take, clk, rst_n, stat.res_push, stat.take && !stat.res_full)
    `SPB_ASSERT_NEXT(a_result_shows, clk, rst_n, stat.res_push, !empty)
    `SPB_ASSERT_NEXT(a_full_holds_head, clk, rst_n, full && !head_pop, full)

endmodule

/* sim/spead_beam_header_parser_test.sv */
// Self-checking testbench for the SPEAD-64-48 beam packet header parser.
`timescale 1ns / 100ps

module spead_beam_header_parser_test;

    import spb_pkg::*;

    class packet_checker;
        bit                   kind;
        bit [15:0]            items_due;
        bit [15:0]            position;
        bit                   header_ok;
        bit                   mode_ok;
        bit [23:0]            heap;
        bit [15:0]            pkt_index;
        bit [47:0]            length;
        bit [47:0]            sync;
        bit [47:0]            stamp;
        bit [39:0]            channel;
        bit [23:0]            tile;
        bit [31:0]            offset;
        res_t                 awaited[$];
        int                   errors;
        int                   checked;
        int                   status_seen[3];

        function void add_result();
            res_t r;
            r = '0;
            if (!header_ok)
            begin
                r.status = STATUS_BAD_HEADER;
            end
            else if (!mode_ok)
            begin
                r.status = STATUS_BAD_MODE;
            end
            else
            begin
                r.status            = STATUS_OK;
                r.heap_counter      = heap;
                r.heap_index        = pkt_index;
                r.payload_bytes     = length;
                r.sync_epoch        = sync;
                r.time_stamp        = stamp;
                r.beam_number       = channel[39:32];
                r.start_channel     = channel[31:16];
                r.included_channels = channel[15:0];
                r.tile_number       = tile[23:16];
                r.station_number    = tile[15:0];
                r.data_offset       = offset;
            end
            awaited.push_back(r);
        endfunction

        function void note_word(logic [63:0] w, logic f);
            logic [ID_W-1:0]      id;
            logic [ADDR_BITS-1:0] a;
            id = w[62:ADDR_BITS];
            a  = w[ADDR_BITS-1:0];
            if (f)
            begin
                header_ok = w[63:56] == HDR_MAGIC && w[55:48] == HDR_VERSION &&
                            w[47:40] == ITEM_PTR_BYTES && w[39:32] == HEAP_ADDR_BYTES;
                mode_ok   = 1'b0;
                heap      = '0;
                pkt_index = '0;
                length    = '0;
                sync      = '0;
                stamp     = '0;
                channel   = '0;
                tile      = '0;
                offset    = '0;
                items_due = w[15:0];
                position  = '0;
                if (items_due == 0)
                    add_result();
            end
            else if (items_due != 0)
            begin
                position++;
                case (id)
                    ID_HEAP_COUNTER:
                    begin
                        heap      = a[23:0];
                        pkt_index = a[39:24];
                    end
                    ID_PAYLOAD_LEN:  length  = a[47:0];
                    ID_SYNC_EPOCH:   sync    = a[47:0];
                    ID_TIME_STAMP:   stamp   = a[47:0];
                    ID_CHANNEL_INFO: channel = a[39:0];
                    ID_TILE_INFO:    tile    = a[39:16];
                    ID_DATA_OFFSET:  offset  = a[31:0];
                    default: ;
                endcase
                if (position == 16'd5)
                    mode_ok = kind ? (a inside {MODE_INTEG_A, MODE_INTEG_B})
                                   : (a == MODE_BURST);
                items_due--;
                if (items_due == 0)
                    add_result();
            end
        endfunction

        task report(string msg);
            $display("ERROR: result %0d: %s", checked, msg);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got_v, logic [63:0] exp_v);
            if (got_v !== exp_v)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got_v, exp_v));
        endtask

        task check_result(res_t got);
            res_t exp;
            checked++;
            if (awaited.size() == 0)
            begin
                report("result with no request to account for it");
                return;
            end
            exp = awaited.pop_front();
            status_seen[int'(exp.status)]++;
            compare_field("status", got.status, exp.status);
            compare_field("heap_counter", got.heap_counter, exp.heap_counter);
            compare_field("heap_index", got.heap_index, exp.heap_index);
            compare_field("payload_bytes", got.payload_bytes, exp.payload_bytes);
            compare_field("sync_epoch", got.sync_epoch, exp.sync_epoch);
            compare_field("time_stamp", got.time_stamp, exp.time_stamp);
            compare_field("beam_number", got.beam_number, exp.beam_number);
            compare_field("start_channel", got.start_channel, exp.start_channel);
            compare_field("included_channels", got.included_channels,
                          exp.included_channels);
            compare_field("tile_number", got.tile_number, exp.tile_number);
            compare_field("station_number", got.station_number, exp.station_number);
            compare_field("data_offset", got.data_offset, exp.data_offset);
        endtask
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        stream_kind_we = 1'b0;
    logic        stream_kind    = 1'b0;
    logic        push           = 1'b0;
    logic        full;
    logic [63:0] word           = '0;
    logic        first          = 1'b0;
    logic        empty;
    logic        pop            = 1'b0;
    logic [1:0]  status;
    logic [23:0] heap_counter;
    logic [15:0] heap_index;
    logic [47:0] payload_bytes;
    logic [47:0] sync_epoch;
    logic [47:0] time_stamp;
    logic [7:0]  beam_number;
    logic [15:0] start_channel;
    logic [15:0] included_channels;
    logic [7:0]  tile_number;
    logic [15:0] station_number;
    logic [31:0] data_offset;

    packet_checker   sb = new();
    int              words_sent;
    int              burst_left;
    int              pop_run;
    int              pop_style;
    bit              pop_on;
    logic [ID_W-1:0] item_ids[8] = '{ID_HEAP_COUNTER, ID_PAYLOAD_LEN, ID_SYNC_EPOCH,
                                     ID_TIME_STAMP, ID_CHANNEL_INFO, ID_TILE_INFO,
                                     ID_SCAN_ID, ID_DATA_OFFSET};

    spead_beam_header_parser uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .stream_kind_we    (stream_kind_we),
        .stream_kind       (stream_kind),
        .push              (push),
        .full              (full),
        .word              (word),
        .first             (first),
        .empty             (empty),
        .pop               (pop),
        .status            (status),
        .heap_counter      (heap_counter),
        .heap_index        (heap_index),
        .payload_bytes     (payload_bytes),
        .sync_epoch        (sync_epoch),
        .time_stamp        (time_stamp),
        .beam_number       (beam_number),
        .start_channel     (start_channel),
        .included_channels (included_channels),
        .tile_number       (tile_number),
        .station_number    (station_number),
        .data_offset       (data_offset)
    );

    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("spead_beam_header_parser_test failed");
        $finish;
    end

    // receiver: pop continuously or alternate pop runs and stalls, switching style now and then
    always @(negedge clk)
    begin
        if (pop_run != 0)
        begin
            pop_run--;
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                pop_style = $urandom_range(0, 2);
            pop_on  = (pop_style == 0) ? 1'b1 : !pop_on;
            pop_run = pop_on ? $urandom_range(0, 12)
                             : (pop_style == 1 ? $urandom_range(0, 2) : $urandom_range(3, 20));
        end
        pop <= pop_on;
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && pop && !empty)
        begin
            got.status            = status_t'(status);
            got.heap_counter      = heap_counter;
            got.heap_index        = heap_index;
            got.payload_bytes     = payload_bytes;
            got.sync_epoch        = sync_epoch;
            got.time_stamp        = time_stamp;
            got.beam_number       = beam_number;
            got.start_channel     = start_channel;
            got.included_channels = included_channels;
            got.tile_number       = tile_number;
            got.station_number    = station_number;
            got.data_offset       = data_offset;
            sb.check_result(got);
        end
    end

    function automatic logic [63:0] make_header(logic [15:0] count, int bad_field);
        logic [7:0] f[4];
        f[0] = HDR_MAGIC;
        f[1] = HDR_VERSION;
        f[2] = ITEM_PTR_BYTES;
        f[3] = HEAP_ADDR_BYTES;
        if (bad_field >= 1 && bad_field <= 4)
            f[bad_field-1] = f[bad_field-1] ^ 8'($urandom_range(1, 255));
        return {f[0], f[1], f[2], f[3], 16'($urandom), count};
    endfunction

    function automatic logic [63:0] make_item(logic imm, logic [ID_W-1:0] id,
                                              logic [47:0] v);
        return {imm, id, v};
    endfunction

    function automatic logic [47:0] rand_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 48'(1) << $urandom_range(0, 47);
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [47:0] pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 6)
            return sb.kind ? ($urandom_range(0, 1) ? MODE_INTEG_A : MODE_INTEG_B) : MODE_BURST;
        if (r == 7)
            case ($urandom_range(0, 2))
                0: return MODE_BURST;
                1: return MODE_INTEG_A;
                default: return MODE_INTEG_B;
            endcase
        if (r == 8)
            return MODE_BURST | (48'(1) << $urandom_range(4, 47));
        return rand_value();
    endfunction

    task send_word(logic [63:0] w, logic f);
        int idle_n;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle_n     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (idle_n)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        push  <= 1'b1;
        word  <= w;
        first <= f;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_word(w, f);
        words_sent++;
    endtask

    task drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task write_kind(bit v);
        drain();
        @(negedge clk);
        stream_kind_we <= 1'b1;
        stream_kind    <= v;
        sb.kind = v;
        @(negedge clk);
        stream_kind_we <= 1'b0;
    endtask

    // send a header and the first cut of its items; a short cut leaves the packet open
    task send_packet(int count, int bad_field, int cut);
        logic [47:0] v;
        send_word(make_header(16'(count), bad_field), 1'b1);
        for (int i = 1; i <= cut; i++)
        begin
            v = (i == 5) ? pick_mode() : rand_value();
            send_word(make_item(1'($urandom), ($urandom_range(0, 8) == 8) ?
                                ID_W'($urandom) : item_ids[$urandom_range(0, 7)], v), 1'b0);
        end
    endtask

    task run_random(int target);
        int start;
        int count;
        start = words_sent;
        while (words_sent - start < target)
        begin
            case ($urandom_range(0, 19))
                0: send_word({$urandom, $urandom}, 1'($urandom));
                1:
                begin
                    count = $urandom_range(5, 10);
                    send_packet(count, 0, $urandom_range(1, count - 1));
                end
                2:
                begin
                    count = $urandom_range(0, 10);
                    send_packet(count, $urandom_range(1, 4), count);
                end
                3:
                begin
                    count = $urandom_range(0, 4);
                    send_packet(count, 0, count);
                end
                4:
                begin
                    count = $urandom_range(11, 40);
                    send_packet(count, 0, count);
                end
                default:
                begin
                    count = $urandom_range(5, 10);
                    send_packet(count, 0, count);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_kind(1'b0);

        send_word(make_header(16'd0, 0), 1'b1);
        send_word(make_header(16'd0, 1), 1'b1);
        send_word('1, 1'b0);
        send_word(make_header(16'd8, 0), 1'b1);
        send_word(make_item(1'b0, ID_HEAP_COUNTER, '1), 1'b0);
        send_word(make_item(1'b1, ID_PAYLOAD_LEN, '1), 1'b0);
        send_word(make_item(1'b0, ID_SYNC_EPOCH, '0), 1'b0);
        send_word(make_item(1'b1, ID_TIME_STAMP, '1), 1'b0);
        send_word(make_item(1'b0, ID_SCAN_ID, MODE_BURST), 1'b0);
        send_word(make_item(1'b1, ID_CHANNEL_INFO, '1), 1'b0);
        send_word(make_item(1'b1, ID_TILE_INFO, '1), 1'b0);
        send_word(make_item(1'b0, ID_DATA_OFFSET, '1), 1'b0);
        send_word(make_header(16'd3, 2), 1'b1);
        send_word(make_item(1'b0, ID_HEAP_COUNTER, 48'h00AB_CDEF_1234), 1'b0);
        send_word(make_item(1'b0, ID_PAYLOAD_LEN, 48'd8192), 1'b0);
        send_word(make_item(1'b0, ID_DATA_OFFSET, 48'h1234), 1'b0);
        send_word(make_header(16'd6, 0), 1'b1);
        send_word(make_item(1'b0, ID_SYNC_EPOCH, 48'h5555_5555_5555), 1'b0);
        send_word(make_item(1'b0, ID_TIME_STAMP, 48'hAAAA_AAAA_AAAA), 1'b0);
        send_word(make_header(16'd5, 0), 1'b1);
        send_word(make_item(1'b0, ID_HEAP_COUNTER, 48'h11_2233_4455), 1'b0);
        send_word(make_item(1'b0, ID_HEAP_COUNTER, 48'h66_7788_99AA), 1'b0);
        send_word(make_item(1'b1, ID_W'(16'h7FFF), '1), 1'b0);
        send_word(make_item(1'b0, ID_PAYLOAD_LEN, 48'd1024), 1'b0);
        send_word(make_item(1'b0, ID_CHANNEL_INFO, MODE_INTEG_A), 1'b0);

        run_random(300);
        write_kind(1'b1);
        run_random(300);
        write_kind(1'b0);
        run_random(140);
        drain();
        run_random(140);
        write_kind(1'b1);
        run_random(230);

        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.awaited.size()));

        $display("Sent %0d words over both stream kinds; checked %0d packet results",
                 words_sent, sb.checked);
        $display("Results by status: %0d accepted, %0d bad header, %0d bad mode",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        if (sb.errors == 0)
            $display("spead_beam_header_parser_test passed");
        else
            $display("spead_beam_header_parser_test failed");
        $finish;
    end

endmodule
